// ----- hw/rtl/h2l_pkg.sv -----
package h2l_pkg;

  // Field widths of the two channels.
  localparam int unsigned SEP_W = 16;
  localparam int unsigned OV_W  = 17;
  localparam int unsigned RES_W = 32;

  // Internal fixed point carries 30 fraction bits.
  localparam int unsigned IQ = 30;

  localparam logic [30:0]        LOG2E_Q     = 31'd1549082005;
  localparam logic [29:0]        LN2_Q       = 30'd744261118;
  localparam logic [28:0]        EH_Q24      = 29'd456531301;
  localparam logic signed [35:0] E1S_Q       = -36'sd14609001619;
  localparam logic [31:0]        DEN_FLOOR_Q = 32'd1074;

  // Number of series terms after the leading one in exp(-t).
  localparam int unsigned SERIES_TERMS = 14;

  // Width of the reciprocal 1/R and of the quotients before saturation.
  localparam int unsigned INV_W = 34;
  localparam int unsigned QUO_W = 34;

endpackage

// ----- hw/rtl/h2l_in_if.sv -----
interface h2l_in_if;
  logic                       valid;
  logic                       ready;
  logic [h2l_pkg::SEP_W-1:0]  separation;
  logic [h2l_pkg::OV_W-1:0]   overlap;

  modport source (output valid, output separation, output overlap, input ready);
  modport sink (input valid, input separation, input overlap, output ready);
endinterface

// ----- hw/rtl/h2l_out_if.sv -----
interface h2l_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [h2l_pkg::RES_W-1:0]  coulomb_element;
  logic signed [h2l_pkg::RES_W-1:0]  exchange_element;
  logic signed [h2l_pkg::RES_W-1:0]  bonding_energy;
  logic signed [h2l_pkg::RES_W-1:0]  antibonding_energy;
  logic                              saturated;

  modport source (output valid, output coulomb_element, output exchange_element,
                  output bonding_energy, output antibonding_energy, output saturated,
                  input ready);
  modport sink (input valid, input coulomb_element, input exchange_element,
                input bonding_energy, input antibonding_energy, input saturated,
                output ready);
endinterface

// ----- hw/rtl/h2_ion_lcao_energies.sv -----
// Results are presented from an output register.
// Throughput: one item per cycle; the 34-step reciprocal, the 14-term exponential
// series and the two 34-step quotient dividers are all unrolled into pipeline stages.
// A stalled output holds the whole pipeline; no item is lost or repeated.
// Reset clears only the valid bits of the stages; the datapath is not reset.
module h2_ion_lcao_energies #(
  parameter int unsigned SEP_FRAC_BITS = 12,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  h2l_in_if.sink     in_i,
  h2l_out_if.source  out_o
);

  localparam int unsigned SEP_W = h2l_pkg::SEP_W;
  localparam int unsigned OV_W  = h2l_pkg::OV_W;
  localparam int unsigned IQ    = h2l_pkg::IQ;
  localparam int unsigned INV_W = h2l_pkg::INV_W;
  localparam int unsigned QUO_W = h2l_pkg::QUO_W;
  localparam int unsigned NT    = h2l_pkg::SERIES_TERMS;

  localparam int unsigned SH_R  = IQ - SEP_FRAC_BITS;
  localparam int unsigned Y2_W  = SEP_W + SH_R + 1;
  localparam int unsigned YI_W  = Y2_W - IQ;
  localparam int unsigned Z_W   = YI_W + 32;
  localparam int unsigned N_W   = Z_W - IQ;
  localparam int unsigned PF_W  = IQ + 31;
  localparam int unsigned T_W   = 30;
  localparam int unsigned E_W   = IQ + 1;
  localparam int unsigned SUM_W = IQ + 3;
  localparam int unsigned RM_SH = 35;
  localparam int unsigned RM_W  = 35;
  localparam int unsigned A_W   = INV_W + 1;
  localparam int unsigned B_W   = SEP_W + E_W - SEP_FRAC_BITS + 1;
  localparam int unsigned H_W   = 44;
  localparam int unsigned SM_W  = H_W + 1;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned P_W   = 72;
  localparam int unsigned RSH   = IQ - OUT_FRAC_BITS;

  localparam int unsigned FR_N  = INV_W;
  localparam int unsigned DV_N  = QUO_W + 1;
  localparam int unsigned TOT   = FR_N + 1 + 4 + DV_N + 1 + 1;

  localparam logic [SEP_W-1:0] RMIN =
      SEP_W'(((64'd1 << SEP_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [IQ:0]      ONE_Q = (IQ + 1)'(1) << IQ;
  localparam logic signed [H_W-1:0] E1S_H = H_W'(h2l_pkg::E1S_Q);

  typedef struct packed {
    logic [SEP_W-1:0]        s;
    logic [OV_W-1:0]         ov;
    logic [SEP_W-1:0]        rem;
    logic [INV_W-1:0]        quo;
    logic [Z_W-1:0]          z1;
    logic [Z_W-1:0]          z2;
    logic [N_W-1:0]          n1;
    logic [N_W-1:0]          n2;
    logic [T_W-1:0]          t1;
    logic [T_W-1:0]          t2;
    logic [E_W-1:0]          m1;
    logic [E_W-1:0]          m2;
    logic signed [SUM_W-1:0] u1;
    logic signed [SUM_W-1:0] u2;
    logic [E_W-1:0]          e1;
    logic [E_W-1:0]          e2;
  } front_t;

  typedef struct packed {
    logic [OV_W-1:0]       ov;
    logic [A_W-1:0]        a;
    logic [B_W-1:0]        bq;
    logic signed [H_W-1:0] mp;
    logic signed [H_W-1:0] haa;
    logic signed [H_W-1:0] mid;
    logic signed [H_W-1:0] eb;
    logic signed [H_W-1:0] hm;
    logic signed [H_W-1:0] hab;
  } back_t;

  typedef struct packed {
    logic [31:0]      c_out;
    logic [31:0]      x_out;
    logic             flag;
    logic             negp;
    logic             negm;
    logic [SM_W-1:0]  magp;
    logic [SM_W-1:0]  magm;
    logic [DEN_W-1:0] denp;
    logic [DEN_W-1:0] denm;
    logic             ovp;
    logic             ovm;
    logic [DEN_W-1:0] remp;
    logic [DEN_W-1:0] remm;
    logic [QUO_W-1:0] qp;
    logic [QUO_W-1:0] qm;
  } div_t;

  typedef struct packed {
    logic [31:0] c_out;
    logic [31:0] x_out;
    logic [31:0] b_out;
    logic [31:0] a_out;
    logic        flag;
  } res_t;

  function automatic logic [Z_W-1:0] exp_z(input logic [Y2_W-1:0] y);
    logic [PF_W-1:0] pf;
    logic [Z_W-1:0]  pi;
    pf = PF_W'(y[IQ-1:0]) * PF_W'(h2l_pkg::LOG2E_Q);
    pi = Z_W'(y[Y2_W-1:IQ]) * Z_W'(h2l_pkg::LOG2E_Q);
    return pi + Z_W'(pf >> IQ);
  endfunction

  function automatic logic [T_W-1:0] exp_t(input logic [IQ-1:0] f);
    logic [PF_W-1:0] p;
    p = PF_W'(f) * PF_W'(h2l_pkg::LN2_Q);
    return T_W'(p >> IQ);
  endfunction

  function automatic logic [E_W-1:0] ser_mul(input logic [E_W-1:0] m,
                                             input logic [T_W-1:0] t);
    logic [PF_W+1:0] p;
    p = (PF_W + 2)'(m) * (PF_W + 2)'(t);
    return E_W'(p >> IQ);
  endfunction

  // Division by a small constant k through a reciprocal; exact for these operands.
  function automatic logic [E_W-1:0] ser_div(input logic [E_W-1:0] x, input int k,
                                             input logic [RM_W-1:0] m);
    logic [E_W+RM_W-1:0] p;
    p = (E_W + RM_W)'(x) * (E_W + RM_W)'(m);
    if (k == 1) begin
      return x;
    end
    return E_W'(p >> RM_SH);
  endfunction

  function automatic logic [E_W-1:0] exp_fin(input logic signed [SUM_W-1:0] u,
                                             input logic [N_W-1:0] n);
    logic [IQ:0] c;
    if (u[SUM_W-1]) begin
      c = '0;
    end else if (u[SUM_W-2:0] > (SUM_W - 1)'(ONE_Q)) begin
      c = ONE_Q;
    end else begin
      c = u[IQ:0];
    end
    if (n > N_W'(IQ)) begin
      return '0;
    end
    return E_W'(c >> n);
  endfunction

  function automatic logic [32:0] sat32(input logic neg, input logic [SM_W-1:0] mag);
    if (!neg) begin
      if (mag > SM_W'(32'h7FFF_FFFF)) begin
        return {1'b1, 32'h7FFF_FFFF};
      end
      return {1'b0, mag[31:0]};
    end
    if (mag > SM_W'(33'h1_0000_0000 >> 1)) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, 32'(~mag[31:0] + 32'd1)};
  endfunction

  function automatic logic [32:0] q30_out(input logic signed [H_W-1:0] v);
    logic signed [SM_W-1:0] w;
    logic [SM_W-1:0]        mag;
    w   = SM_W'(v);
    mag = v[H_W-1] ? SM_W'(-w) : SM_W'(w);
    mag = (mag + (SM_W'(1) << (RSH - 1))) >> RSH;
    return sat32(v[H_W-1], mag);
  endfunction

  logic [TOT-1:0] vld_q;
  logic           adv;

  front_t fr_q [FR_N+1];
  front_t fr0_d;
  back_t  b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, b4_q, b4_d;
  div_t   dv_q [DV_N+1];
  div_t   dv0_d, dv1_d;
  res_t   out_q, out_d;

  assign adv        = !vld_q[TOT-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOT-2:0], in_i.valid};
    end
  end

  // Input stage: clamp the separation and seed the reciprocal remainder.
  always_comb begin
    fr0_d     = '0;
    fr0_d.s   = (in_i.separation < RMIN) ? RMIN : in_i.separation;
    fr0_d.ov  = in_i.overlap;
    fr0_d.rem = SEP_W'(1) << (SEP_FRAC_BITS - 4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fr_q[0] <= fr0_d;
    end
  end

  // Reciprocal 2^(30+SEP_FRAC_BITS)/s one quotient bit per stage, with the two
  // exponentials evaluated alongside: argument split, then one series term in two stages.
  for (genvar j = 1; j <= FR_N; j++) begin : g_fr
    localparam int K     = (j - 1) / 2;
    localparam int K_DIV = (K < 2) ? 1 : K;
    localparam logic [RM_W-1:0] RECIP_M =
        RM_W'(((64'd1 << RM_SH) + 64'(K_DIV) - 64'd1) / 64'(K_DIV));
    front_t         d;
    logic [SEP_W:0] rs;

    always_comb begin
      d  = fr_q[j-1];
      rs = {fr_q[j-1].rem, 1'b0};
      if (rs >= {1'b0, fr_q[j-1].s}) begin
        d.rem = SEP_W'(rs - {1'b0, fr_q[j-1].s});
        d.quo = {fr_q[j-1].quo[INV_W-2:0], 1'b1};
      end else begin
        d.rem = rs[SEP_W-1:0];
        d.quo = {fr_q[j-1].quo[INV_W-2:0], 1'b0};
      end
      if (j == 1) begin
        d.z1 = exp_z(Y2_W'(fr_q[j-1].s) << SH_R);
        d.z2 = exp_z(Y2_W'(fr_q[j-1].s) << (SH_R + 1));
      end else if (j == 2) begin
        d.n1 = fr_q[j-1].z1[Z_W-1:IQ];
        d.n2 = fr_q[j-1].z2[Z_W-1:IQ];
        d.t1 = exp_t(fr_q[j-1].z1[IQ-1:0]);
        d.t2 = exp_t(fr_q[j-1].z2[IQ-1:0]);
        d.m1 = E_W'(ONE_Q);
        d.m2 = E_W'(ONE_Q);
        d.u1 = $signed(SUM_W'(ONE_Q));
        d.u2 = $signed(SUM_W'(ONE_Q));
      end else if (j <= 2 * NT + 2) begin
        if (j % 2 == 1) begin
          d.m1 = ser_mul(fr_q[j-1].m1, fr_q[j-1].t1);
          d.m2 = ser_mul(fr_q[j-1].m2, fr_q[j-1].t2);
        end else begin
          d.m1 = ser_div(fr_q[j-1].m1, K, RECIP_M);
          d.m2 = ser_div(fr_q[j-1].m2, K, RECIP_M);
          if (K % 2 == 1) begin
            d.u1 = fr_q[j-1].u1 - $signed(SUM_W'(d.m1));
            d.u2 = fr_q[j-1].u2 - $signed(SUM_W'(d.m2));
          end else begin
            d.u1 = fr_q[j-1].u1 + $signed(SUM_W'(d.m1));
            d.u2 = fr_q[j-1].u2 + $signed(SUM_W'(d.m2));
          end
        end
      end else if (j == 2 * NT + 3) begin
        d.e1 = exp_fin(fr_q[j-1].u1, fr_q[j-1].n1);
        d.e2 = exp_fin(fr_q[j-1].u2, fr_q[j-1].n2);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fr_q[j] <= d;
      end
    end
  end

  // e1 is exp(-R), e2 is exp(-2R); R*e1 is taken from s to keep the product narrow.
  always_comb begin
    logic [P_W-1:0] pa;
    logic [P_W-1:0] pb;
    logic [P_W-1:0] pm;
    pa = P_W'(fr_q[FR_N].quo) * P_W'(fr_q[FR_N].e2);
    pb = P_W'(fr_q[FR_N].s) * P_W'(fr_q[FR_N].e1);
    pm = P_W'(h2l_pkg::EH_Q24) * P_W'(fr_q[FR_N].quo);
    b1_d    = '0;
    b1_d.ov = fr_q[FR_N].ov;
    b1_d.a  = A_W'((pa >> IQ) + P_W'(fr_q[FR_N].e2));
    b1_d.bq = B_W'((pb >> SEP_FRAC_BITS) + P_W'(fr_q[FR_N].e1));
    b1_d.mp = $signed(H_W'(pm >> 24));
  end

  always_comb begin
    logic [P_W-1:0] ph;
    logic [P_W-1:0] pe;
    ph = P_W'(h2l_pkg::EH_Q24) * P_W'(b1_q.a);
    pe = P_W'(h2l_pkg::EH_Q24) * P_W'(b1_q.bq);
    b2_d     = b1_q;
    b2_d.haa = E1S_H + $signed(H_W'(ph >> 24));
    b2_d.mid = E1S_H + b1_q.mp;
    b2_d.eb  = $signed(H_W'(pe >> 24));
  end

  // The product with S is truncated toward zero.
  always_comb begin
    logic signed [H_W+OV_W:0] p;
    logic signed [H_W+OV_W:0] pr;
    p  = b2_q.mid * $signed({1'b0, b2_q.ov});
    pr = p + (p[H_W+OV_W] ? (H_W + OV_W + 1)'(16'hFFFF) : '0);
    b3_d    = b2_q;
    b3_d.hm = H_W'(pr >>> 16);
  end

  always_comb begin
    b4_d     = b3_q;
    b4_d.hab = b3_q.hm - b3_q.eb;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
    end
  end

  always_comb begin
    logic signed [SM_W-1:0] sp;
    logic signed [SM_W-1:0] sm;
    logic [32:0]            rc;
    logic [32:0]            rx;
    logic [DEN_W-1:0]       sq;
    logic [DEN_W-1:0]       dm;
    sp = SM_W'(b4_q.haa) + SM_W'(b4_q.hab);
    sm = SM_W'(b4_q.haa) - SM_W'(b4_q.hab);
    rc = q30_out(b4_q.haa);
    rx = q30_out(b4_q.hab);
    sq = DEN_W'(b4_q.ov) << (IQ - 16);
    dm = (sq < DEN_W'(ONE_Q)) ? (DEN_W'(ONE_Q) - sq) : '0;
    if (dm < h2l_pkg::DEN_FLOOR_Q) begin
      dm = h2l_pkg::DEN_FLOOR_Q;
    end
    dv0_d       = '0;
    dv0_d.c_out = rc[31:0];
    dv0_d.x_out = rx[31:0];
    dv0_d.flag  = rc[32] | rx[32];
    dv0_d.negp  = sp[SM_W-1];
    dv0_d.negm  = sm[SM_W-1];
    dv0_d.magp  = sp[SM_W-1] ? SM_W'(-sp) : SM_W'(sp);
    dv0_d.magm  = sm[SM_W-1] ? SM_W'(-sm) : SM_W'(sm);
    dv0_d.denp  = DEN_W'(ONE_Q) + sq;
    dv0_d.denm  = dm;
  end

  // A quotient of 2^QUO_W or more saturates in any case, so it is caught up front.
  always_comb begin
    dv1_d      = dv_q[0];
    dv1_d.ovp  = 64'(dv_q[0].magp) >= (64'(dv_q[0].denp) << (QUO_W - OUT_FRAC_BITS));
    dv1_d.ovm  = 64'(dv_q[0].magm) >= (64'(dv_q[0].denm) << (QUO_W - OUT_FRAC_BITS));
    dv1_d.remp = DEN_W'(dv_q[0].magp >> (QUO_W - OUT_FRAC_BITS));
    dv1_d.remm = DEN_W'(dv_q[0].magm >> (QUO_W - OUT_FRAC_BITS));
    dv1_d.qp   = '0;
    dv1_d.qm   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv0_d;
      dv_q[1] <= dv1_d;
    end
  end

  // Restoring division: each stage brings in one bit of mag * 2^OUT_FRAC_BITS.
  for (genvar j = 2; j <= DV_N; j++) begin : g_dv
    localparam int B   = DV_N - j;
    localparam bit HAS = (B >= OUT_FRAC_BITS);
    localparam int BI  = HAS ? (B - OUT_FRAC_BITS) : 0;
    div_t           d;
    logic [DEN_W:0] rsp;
    logic [DEN_W:0] rsm;

    always_comb begin
      d   = dv_q[j-1];
      rsp = {dv_q[j-1].remp, HAS ? dv_q[j-1].magp[BI] : 1'b0};
      rsm = {dv_q[j-1].remm, HAS ? dv_q[j-1].magm[BI] : 1'b0};
      if (rsp >= {1'b0, dv_q[j-1].denp}) begin
        d.remp = DEN_W'(rsp - {1'b0, dv_q[j-1].denp});
        d.qp   = {dv_q[j-1].qp[QUO_W-2:0], 1'b1};
      end else begin
        d.remp = rsp[DEN_W-1:0];
        d.qp   = {dv_q[j-1].qp[QUO_W-2:0], 1'b0};
      end
      if (rsm >= {1'b0, dv_q[j-1].denm}) begin
        d.remm = DEN_W'(rsm - {1'b0, dv_q[j-1].denm});
        d.qm   = {dv_q[j-1].qm[QUO_W-2:0], 1'b1};
      end else begin
        d.remm = rsm[DEN_W-1:0];
        d.qm   = {dv_q[j-1].qm[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j] <= d;
      end
    end
  end

  always_comb begin
    logic [32:0] rb;
    logic [32:0] ra;
    rb = sat32(dv_q[DV_N].negp,
               dv_q[DV_N].ovp ? (SM_W'(1) << QUO_W) : SM_W'(dv_q[DV_N].qp));
    ra = sat32(dv_q[DV_N].negm,
               dv_q[DV_N].ovm ? (SM_W'(1) << QUO_W) : SM_W'(dv_q[DV_N].qm));
    out_d.c_out = dv_q[DV_N].c_out;
    out_d.x_out = dv_q[DV_N].x_out;
    out_d.b_out = rb[31:0];
    out_d.a_out = ra[31:0];
    out_d.flag  = dv_q[DV_N].flag | rb[32] | ra[32];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid              = vld_q[TOT-1];
  assign out_o.coulomb_element    = $signed(out_q.c_out);
  assign out_o.exchange_element   = $signed(out_q.x_out);
  assign out_o.bonding_energy     = $signed(out_q.b_out);
  assign out_o.antibonding_energy = $signed(out_q.a_out);
  assign out_o.saturated          = out_q.flag;

endmodule

// ----- test/h2_ion_lcao_energies_tb.sv -----
module h2_ion_lcao_energies_tb;

  localparam int unsigned SEP_FRAC = 12;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned N_RANDOM = 1600;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned IQ = h2l_pkg::IQ;
  localparam int unsigned SEP_W = h2l_pkg::SEP_W;
  localparam int unsigned OV_W = h2l_pkg::OV_W;
  localparam int unsigned RES_W = h2l_pkg::RES_W;
  localparam logic [63:0] Q_ONE = 64'd1 << IQ;
  localparam logic [63:0] Q_MASK = Q_ONE - 64'd1;
  localparam logic [63:0] QUOT_LIMIT = 64'd1 << 33;

  typedef struct {
    logic signed [RES_W-1:0] haa;
    logic signed [RES_W-1:0] hab;
    logic signed [RES_W-1:0] bond;
    logic signed [RES_W-1:0] anti;
    logic                    sat;
  } energies_t;

  typedef struct {
    logic [SEP_W-1:0] sep;
    logic [OV_W-1:0]  ov;
  } point_t;

  logic clk_i;
  logic rst_ni;
  int unsigned cycles;
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_clipped;
  bit calm;
  bit hold_req;
  energies_t energies_q[$];

  h2l_in_if  in_if ();
  h2l_out_if out_if ();

  h2_ion_lcao_energies #(
    .SEP_FRAC_BITS(SEP_FRAC),
    .OUT_FRAC_BITS(OUT_FRAC)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    cycles = 0;
    forever begin
      #5 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("%0t: timeout with %0d items outstanding", $realtime, energies_q.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // exp(-y) for a Q30 argument, by range reduction to a power of two and a series.
  function automatic logic [63:0] exp_decay(logic [63:0] y);
    logic [63:0] yi, yf, z, n, f, t, term;
    longint sum;
    yi = y >> IQ;
    yf = y & Q_MASK;
    z = yi * 64'(h2l_pkg::LOG2E_Q) + ((yf * 64'(h2l_pkg::LOG2E_Q)) >> IQ);
    n = z >> IQ;
    if (n > IQ) return 64'd0;
    f = z & Q_MASK;
    t = (f * 64'(h2l_pkg::LN2_Q)) >> IQ;
    sum = longint'(Q_ONE);
    term = Q_ONE;
    for (int k = 1; k <= h2l_pkg::SERIES_TERMS; k++) begin
      term = ((term * t) >> IQ) / 64'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(Q_ONE)) sum = longint'(Q_ONE);
    return 64'(sum) >> n;
  endfunction

  function automatic logic [31:0] clip32(bit neg, logic [63:0] mag, inout bit flag);
    logic [63:0] v;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        flag = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 64'h8000_0000) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    v = 64'd0 - mag;
    return v[31:0];
  endfunction

  function automatic logic [31:0] q30_round(longint x, inout bit flag);
    bit neg;
    logic [63:0] mag;
    int unsigned sh;
    neg = x < 0;
    mag = neg ? 64'(-x) : 64'(x);
    sh = IQ - OUT_FRAC;
    if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return clip32(neg, mag, flag);
  endfunction

  // Restoring division toward zero, with OUT_FRAC fraction bits in the quotient.
  function automatic logic [31:0] quotient(longint num, logic [63:0] den, inout bit flag);
    bit neg;
    logic [63:0] mag, q, rem;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    q = mag / den;
    rem = mag % den;
    if (q >= QUOT_LIMIT) return clip32(neg, QUOT_LIMIT, flag);
    for (int i = 0; i < OUT_FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
      if (q >= QUOT_LIMIT) return clip32(neg, QUOT_LIMIT, flag);
    end
    return clip32(neg, q, flag);
  endfunction

  function automatic energies_t lcao_energies(logic [SEP_W-1:0] sep, logic [OV_W-1:0] ov);
    energies_t e;
    logic [63:0] rmin, s, r, invr, e1, e2, a, b, sq, dp, dm;
    longint haa, hab, mid;
    bit flag;
    flag = 1'b0;
    rmin = ((64'd1 << SEP_FRAC) + 64'd5) / 64'd10;
    s = 64'(sep);
    if (s < rmin) s = rmin;
    r = s << (IQ - SEP_FRAC);
    invr = (64'd1 << 60) / r;
    e2 = exp_decay(2 * r);
    e1 = exp_decay(r);
    a = ((invr * e2) >> IQ) + e2;
    b = ((r * e1) >> IQ) + e1;
    haa = longint'(h2l_pkg::E1S_Q) + longint'((64'(h2l_pkg::EH_Q24) * a) >> 24);
    mid = longint'(h2l_pkg::E1S_Q) + longint'((64'(h2l_pkg::EH_Q24) * invr) >> 24);
    hab = (mid * longint'(ov)) / 65536 - longint'((64'(h2l_pkg::EH_Q24) * b) >> 24);
    sq = 64'(ov) << (IQ - 16);
    dp = Q_ONE + sq;
    dm = (sq < Q_ONE) ? (Q_ONE - sq) : 64'd0;
    if (dm < 64'(h2l_pkg::DEN_FLOOR_Q)) dm = 64'(h2l_pkg::DEN_FLOOR_Q);
    e.haa = q30_round(haa, flag);
    e.hab = q30_round(hab, flag);
    e.bond = quotient(haa + hab, dp, flag);
    e.anti = quotient(haa - hab, dm, flag);
    e.sat = flag;
    return e;
  endfunction

  task automatic send_point(logic [SEP_W-1:0] sep, logic [OV_W-1:0] ov);
    if (!calm && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 14)) begin
        @(posedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.separation <= sep;
    in_if.overlap <= ov;
    // Inputs and outputs are stable at the falling edge, so the handshake is read there.
    do @(negedge clk_i); while (!in_if.ready);
    energies_q.push_back(lcao_energies(sep, ov));
    n_sent++;
  endtask

  task automatic pause_until_drained();
    @(posedge clk_i);
    in_if.valid <= 1'b0;
    wait (energies_q.size() == 0);
  endtask

  function automatic logic [OV_W-1:0] random_overlap();
    case ($urandom_range(0, 9))
      0: return OV_W'($urandom_range(65536, 131071));
      1: return OV_W'($urandom_range(65000, 65536));
      2: return OV_W'($urandom_range(0, 64));
      default: return OV_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [SEP_W-1:0] random_separation();
    case ($urandom_range(0, 9))
      0: return SEP_W'($urandom_range(0, 500));
      1: return SEP_W'($urandom_range(0, 65535));
      default: return SEP_W'($urandom_range(300, 40000));
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold on request, none near the end.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    energies_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (energies_q.size() == 0) begin
        $display("%0t: unexpected item, actual haa=%h", $realtime, out_if.coulomb_element);
        errors++;
      end else begin
        want = energies_q.pop_front();
        n_checked++;
        if (want.sat) n_clipped++;
        if (out_if.coulomb_element !== want.haa) begin
          $display("%0t: coulomb_element expected %h actual %h", $realtime, want.haa,
                   out_if.coulomb_element);
          errors++;
        end
        if (out_if.exchange_element !== want.hab) begin
          $display("%0t: exchange_element expected %h actual %h", $realtime, want.hab,
                   out_if.exchange_element);
          errors++;
        end
        if (out_if.bonding_energy !== want.bond) begin
          $display("%0t: bonding_energy expected %h actual %h", $realtime, want.bond,
                   out_if.bonding_energy);
          errors++;
        end
        if (out_if.antibonding_energy !== want.anti) begin
          $display("%0t: antibonding_energy expected %h actual %h", $realtime, want.anti,
                   out_if.antibonding_energy);
          errors++;
        end
        if (out_if.saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $realtime, want.sat,
                   out_if.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    point_t sweep[] = '{
      '{16'd0, 17'd0}, '{16'd0, 17'd65536}, '{16'd1, 17'd32768},
      '{16'd409, 17'd0}, '{16'd410, 17'd65535}, '{16'd411, 17'd1},
      '{16'd4096, 17'd0}, '{16'd4096, 17'd65536}, '{16'd4096, 17'd131071},
      '{16'd8192, 17'd19661}, '{16'd65535, 17'd0}, '{16'd65535, 17'd65536},
      '{16'd65535, 17'd131071}, '{16'd0, 17'd131071}, '{16'd32768, 17'd65535},
      '{16'hAAAA, 17'h15555}, '{16'h5555, 17'h0AAAA}, '{16'd2048, 17'd98304}
    };
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_clipped = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.separation <= '0;
    in_if.overlap <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (sweep[i]) send_point(sweep[i].sep, sweep[i].ov);
    pause_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 700) pause_until_drained();
      if (i == N_RANDOM - 300) calm = 1'b1;
      send_point(random_separation(), random_overlap());
    end
    @(posedge clk_i);
    in_if.valid <= 1'b0;

    wait (energies_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items over separations 0..65535 and overlaps 0..131071.", n_sent);
    $display("Checked %0d results, %0d of them clipped to range.", n_checked, n_clipped);
    if (errors == 0 && energies_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
